@@ rtl/bis_pkg.sv @@
// Shared types, constants and helper functions of the bilinear image scaler.
package bis_pkg;

  localparam int PIX_W            = 32;
  localparam int CH_W             = 8;
  localparam int CHANNELS         = PIX_W / CH_W;
  localparam int DIM_W            = 13;
  localparam int COORD_W          = 12;
  localparam int SADDR_W          = 16;
  localparam int FRAC_W           = 8;
  localparam int FIX_W            = COORD_W + FRAC_W;
  localparam int NUM_W            = 32;
  localparam int PROD_W           = 25;
  localparam int ROWBASE_W        = 25;
  localparam int DIV_STEPS        = 4;
  localparam int DIV_STAGES       = FIX_W / DIV_STEPS;
  localparam int WEIGHT_W         = FRAC_W + 1;
  localparam int HSUM_W           = 16;
  localparam int VSUM_W           = 24;
  localparam int RND_W            = 25;
  localparam int RND_SHIFT        = 16;
  localparam int CFG_IDX_W        = 2;
  localparam int STORE_PIXELS_DEF = 65536;

  localparam logic [DIM_W-1:0]    MAX_DIM    = 13'd4096;
  localparam logic [DIM_W-1:0]    SIZE_RESET = 13'd256;
  localparam logic [FIX_W-1:0]    HALF_PIXEL = 20'd128;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;
  localparam logic [RND_W-1:0]    ROUND_HALF = 25'd32768;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

  typedef enum logic [1:0] {
    PH_P00,
    PH_P01,
    PH_P10,
    PH_P11
  } phase_t;

  typedef struct packed {
    logic               op;
    logic               bad;
    logic [SADDR_W-1:0] addr;
    logic [PIX_W-1:0]   pixel;
  } tag_t;

  typedef struct packed {
    logic [COORD_W-1:0] near_idx;
    logic [COORD_W-1:0] far_idx;
    logic [FRAC_W-1:0]  frac;
  } axis_t;

  function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = 13'd1;
    end else if (v > MAX_DIM) begin
      r = MAX_DIM;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic axis_t map_axis(input logic [FIX_W-1:0] q, input logic [DIM_W-1:0] src);
    logic [FIX_W-1:0] pos;
    logic [FIX_W-1:0] top;
    axis_t            a;
    pos = (q < HALF_PIXEL) ? '0 : q - HALF_PIXEL;
    top = {COORD_W'(src - 13'd1), {FRAC_W{1'b0}}};
    if (pos > top) begin
      pos = top;
    end
    a.near_idx = pos[FIX_W-1:FRAC_W];
    a.frac     = pos[FRAC_W-1:0];
    a.far_idx  = a.near_idx + ((({1'b0, a.near_idx} + 13'd1) < src) ? 12'd1 : 12'd0);
    return a;
  endfunction

endpackage

@@ rtl/bis_ram.sv @@
// Generic single-port RAM with registered read data.
module bis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/bis_div.sv @@
// Pipelined restoring divider: four quotient bits per stage, one division per cycle while en is high.
module bis_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [bis_pkg::NUM_W-1:0]  num,
  input  logic [bis_pkg::DIM_W-1:0]  den,
  output logic [bis_pkg::FIX_W-1:0]  quo
);

  localparam int STAGES = bis_pkg::DIV_STAGES;
  localparam int STEPS  = bis_pkg::DIV_STEPS;
  localparam int RW     = bis_pkg::DIM_W;
  localparam int QW     = bis_pkg::FIX_W;
  localparam int NW     = bis_pkg::NUM_W;

  logic [RW-1:0] rem_in  [STAGES];
  logic [QW-1:0] nq_in   [STAGES];
  logic [RW-1:0] rem_nxt [STAGES];
  logic [QW-1:0] nq_nxt  [STAGES];
  logic [RW-1:0] rem_r   [STAGES];
  logic [QW-1:0] nq_r    [STAGES];

  assign rem_in[0] = RW'(num[NW-1:QW]);
  assign nq_in[0]  = num[QW-1:0];

  for (genvar s = 1; s < STAGES; s++) begin : g_link
    assign rem_in[s] = rem_r[s-1];
    assign nq_in[s]  = nq_r[s-1];
  end

  always_comb begin
    logic [RW:0]   t;
    logic [RW-1:0] r;
    logic [QW-1:0] q;
    for (int s = 0; s < STAGES; s++) begin
      r = rem_in[s];
      q = nq_in[s];
      for (int k = 0; k < STEPS; k++) begin
        t = {r, q[QW-1]};
        q = {q[QW-2:0], 1'b0};
        if (t >= {1'b0, den}) begin
          t    = t - {1'b0, den};
          q[0] = 1'b1;
        end
        r = t[RW-1:0];
      end
      rem_nxt[s] = r;
      nq_nxt[s]  = q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < STAGES; s++) begin
        rem_r[s] <= rem_nxt[s];
        nq_r[s]  <= nq_nxt[s];
      end
    end
  end

  assign quo = nq_r[STAGES-1];

endmodule

@@ rtl/bilinear_image_scaler.sv @@
// Top level of the bilinear image scaler: front pipeline, frame store sequencer and blend.
//
// Usage:
// - Commands enter on the in_ ports; one is taken at a clock edge with start high and busy low.
//   Opcode write stores in_source_pixel at in_source_address; opcode request asks for the
//   pixel at (in_dest_column, in_dest_row) of the scaled frame.
// - Each request gives one result on the out_ ports, marked by out_valid for one cycle;
//   writes give none. Results come in command order. The receiver cannot stall.
// - Size registers are written over cfg_we/cfg_index/cfg_wdata while no command is in flight.
// - Each command passes the s0, s1, divider, m and iss registers; a write commits at iss,
//   and a request's result is registered through the d, e and out stages after iss.
// - A request holds the single frame store port for one read per neighbour and stalls the
//   pipeline meanwhile; writes and out-of-range requests do not stall it. busy is high
//   while the store sequencer holds a request and has not reached its last read.
// - A 5-stage pipelined divider does the coordinate divisions, one per cycle unless busy.
// - Reset empties the pipeline and sets all four size registers to 256; store contents
//   are undefined until written.
module bilinear_image_scaler #(
  parameter int STORE_PIXELS = bis_pkg::STORE_PIXELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_opcode,
  input  logic [bis_pkg::SADDR_W-1:0]    in_source_address,
  input  logic [bis_pkg::PIX_W-1:0]      in_source_pixel,
  input  logic [bis_pkg::COORD_W-1:0]    in_dest_column,
  input  logic [bis_pkg::COORD_W-1:0]    in_dest_row,
  output logic                           out_valid,
  output logic [bis_pkg::PIX_W-1:0]      out_result_pixel,
  output logic                           out_bad_request,
  input  logic                           cfg_we,
  input  logic [bis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bis_pkg::DIM_W-1:0]      cfg_wdata
);

  localparam int AW      = $clog2(STORE_PIXELS);
  localparam int DS      = bis_pkg::DIV_STAGES;
  localparam int NCH     = bis_pkg::CHANNELS;
  localparam int CW      = bis_pkg::CH_W;
  localparam int DIM_W   = bis_pkg::DIM_W;
  localparam int COORD_W = bis_pkg::COORD_W;
  localparam int FRAC_W  = bis_pkg::FRAC_W;
  localparam int PROD_W  = bis_pkg::PROD_W;
  localparam int RB_W    = bis_pkg::ROWBASE_W;
  localparam int WW      = bis_pkg::WEIGHT_W;
  localparam int HW      = bis_pkg::HSUM_W;
  localparam int VW      = bis_pkg::VSUM_W;
  localparam int RW      = bis_pkg::RND_W;
  localparam int PW      = bis_pkg::PIX_W;

  // size registers, held as effective sizes
  logic [DIM_W-1:0] sw_r, sh_r, dw_r, dh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= bis_pkg::SIZE_RESET;
      sh_r <= bis_pkg::SIZE_RESET;
      dw_r <= bis_pkg::SIZE_RESET;
      dh_r <= bis_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bis_pkg::REG_SRC_WIDTH:  sw_r <= bis_pkg::eff_size(cfg_wdata);
        bis_pkg::REG_SRC_HEIGHT: sh_r <= bis_pkg::eff_size(cfg_wdata);
        bis_pkg::REG_DST_WIDTH:  dw_r <= bis_pkg::eff_size(cfg_wdata);
        bis_pkg::REG_DST_HEIGHT: dh_r <= bis_pkg::eff_size(cfg_wdata);
      endcase
    end
  end

  logic adv;

  // front pipeline
  logic                      s0_valid_r, s1_valid_r, m_valid_r, iss_valid_r;
  logic                      dv_valid_r [DS];
  bis_pkg::tag_t             s0_tag_r, s1_tag_r, m_tag_r, iss_tag_r;
  bis_pkg::tag_t             dv_tag_r [DS];
  bis_pkg::tag_t             in_tag;
  logic [COORD_W-1:0]        s0_col_r, s0_row_r;
  logic [2*DIM_W-1:0]        prod_x, prod_y;
  logic [PROD_W-1:0]         s1_prodx_r, s1_prody_r;
  logic [bis_pkg::FIX_W-1:0] quo_x, quo_y;
  bis_pkg::axis_t            m_x_r, m_y_r;
  bis_pkg::axis_t            iss_x_r;
  logic [FRAC_W-1:0]         iss_fy_r;
  logic [RB_W-1:0]           base_near, base_far;
  logic [RB_W-1:0]           iss_base_near_r, iss_base_far_r;

  always_comb begin
    in_tag.op    = in_opcode;
    in_tag.bad   = ({1'b0, in_dest_column} >= dw_r) || ({1'b0, in_dest_row} >= dh_r);
    in_tag.addr  = in_source_address;
    in_tag.pixel = in_source_pixel;
  end

  assign prod_x = {s0_col_r, 1'b1} * sw_r;
  assign prod_y = {s0_row_r, 1'b1} * sh_r;

  bis_div u_div_x (
    .clk (clk),
    .en  (adv),
    .num ({s1_prodx_r, 7'd0}),
    .den (dw_r),
    .quo (quo_x)
  );

  bis_div u_div_y (
    .clk (clk),
    .en  (adv),
    .num ({s1_prody_r, 7'd0}),
    .den (dh_r),
    .quo (quo_y)
  );

  assign base_near = {{(RB_W-COORD_W){1'b0}}, m_y_r.near_idx}
                   * {{(RB_W-DIM_W){1'b0}}, sw_r};
  assign base_far  = {{(RB_W-COORD_W){1'b0}}, m_y_r.far_idx}
                   * {{(RB_W-DIM_W){1'b0}}, sw_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      m_valid_r   <= 1'b0;
      iss_valid_r <= 1'b0;
      for (int i = 0; i < DS; i++) begin
        dv_valid_r[i] <= 1'b0;
      end
    end else if (adv) begin
      s0_valid_r    <= start;
      s1_valid_r    <= s0_valid_r;
      dv_valid_r[0] <= s1_valid_r;
      for (int i = 1; i < DS; i++) begin
        dv_valid_r[i] <= dv_valid_r[i-1];
      end
      m_valid_r   <= dv_valid_r[DS-1];
      iss_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_tag_r   <= in_tag;
      s0_col_r   <= in_dest_column;
      s0_row_r   <= in_dest_row;
      s1_tag_r   <= s0_tag_r;
      s1_prodx_r <= prod_x[PROD_W-1:0];
      s1_prody_r <= prod_y[PROD_W-1:0];
      dv_tag_r[0] <= s1_tag_r;
      for (int i = 1; i < DS; i++) begin
        dv_tag_r[i] <= dv_tag_r[i-1];
      end
      m_tag_r         <= dv_tag_r[DS-1];
      m_x_r           <= bis_pkg::map_axis(quo_x, sw_r);
      m_y_r           <= bis_pkg::map_axis(quo_y, sh_r);
      iss_tag_r       <= m_tag_r;
      iss_x_r         <= m_x_r;
      iss_fy_r        <= m_y_r.frac;
      iss_base_near_r <= base_near;
      iss_base_far_r  <= base_far;
    end
  end

  // store sequencer
  bis_pkg::phase_t   phase_r, phase_nxt;
  logic              iss_read, iss_bad, iss_write, iss_done;
  logic [RB_W-1:0]   row_base, read_addr;
  logic [COORD_W-1:0] col_sel;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [PW-1:0]     ram_wdata, ram_rdata;

  assign iss_read  = iss_valid_r && (iss_tag_r.op == bis_pkg::OP_REQUEST) && !iss_tag_r.bad;
  assign iss_bad   = iss_valid_r && (iss_tag_r.op == bis_pkg::OP_REQUEST) && iss_tag_r.bad;
  assign iss_write = iss_valid_r && (iss_tag_r.op == bis_pkg::OP_WRITE)
                     && (32'(iss_tag_r.addr) < 32'(STORE_PIXELS));

  always_comb begin
    phase_nxt = phase_r;
    if (iss_read) begin
      unique case (phase_r)
        bis_pkg::PH_P00: phase_nxt = bis_pkg::PH_P01;
        bis_pkg::PH_P01: phase_nxt = bis_pkg::PH_P10;
        bis_pkg::PH_P10: phase_nxt = bis_pkg::PH_P11;
        bis_pkg::PH_P11: phase_nxt = bis_pkg::PH_P00;
      endcase
    end
  end

  always_comb begin
    row_base = iss_base_near_r;
    col_sel  = iss_x_r.near_idx;
    unique case (phase_r)
      bis_pkg::PH_P00: begin
        row_base = iss_base_near_r;
        col_sel  = iss_x_r.near_idx;
      end
      bis_pkg::PH_P01: begin
        row_base = iss_base_near_r;
        col_sel  = iss_x_r.far_idx;
      end
      bis_pkg::PH_P10: begin
        row_base = iss_base_far_r;
        col_sel  = iss_x_r.near_idx;
      end
      bis_pkg::PH_P11: begin
        row_base = iss_base_far_r;
        col_sel  = iss_x_r.far_idx;
      end
    endcase
    read_addr = row_base + RB_W'(col_sel);
    ram_we    = iss_write;
    ram_addr  = iss_write ? AW'(iss_tag_r.addr) : AW'(read_addr);
    ram_wdata = iss_tag_r.pixel;
    iss_done  = iss_valid_r && (!iss_read || (phase_r == bis_pkg::PH_P11));
  end

  assign adv  = !iss_valid_r || iss_done;
  assign busy = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bis_pkg::PH_P00;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  bis_ram #(
    .WIDTH (PW),
    .DEPTH (STORE_PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // blend
  logic              d_read_r, d_bad_r, e_valid_r, e_bad_r;
  bis_pkg::phase_t   d_phase_r;
  logic [FRAC_W-1:0] d_fx_r, d_fy_r, e_fy_r;
  logic [WW-1:0]     d_w, d_wy;
  logic [HW-1:0]     hprod   [NCH];
  logic [VW-1:0]     vprod   [NCH];
  logic [HW-1:0]     hacc_r  [NCH];
  logic [HW-1:0]     upper_r [NCH];
  logic [HW-1:0]     lower_r [NCH];
  logic [VW-1:0]     vacc_r  [NCH];
  logic [RW-1:0]     esum    [NCH];
  logic [PW-1:0]     e_pixel;
  logic              out_valid_r, out_bad_r;
  logic [PW-1:0]     out_pixel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_read_r    <= 1'b0;
      d_bad_r     <= 1'b0;
      e_valid_r   <= 1'b0;
      e_bad_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      d_read_r    <= iss_read;
      d_bad_r     <= iss_bad;
      e_valid_r   <= (d_read_r && (d_phase_r == bis_pkg::PH_P11)) || d_bad_r;
      e_bad_r     <= d_bad_r;
      out_valid_r <= e_valid_r;
    end
  end

  always_comb begin
    if ((d_phase_r == bis_pkg::PH_P00) || (d_phase_r == bis_pkg::PH_P10)) begin
      d_w = bis_pkg::WEIGHT_ONE - {1'b0, d_fx_r};
    end else begin
      d_w = {1'b0, d_fx_r};
    end
    d_wy = bis_pkg::WEIGHT_ONE - {1'b0, d_fy_r};
    for (int c = 0; c < NCH; c++) begin
      hprod[c] = {{(HW-CW){1'b0}}, ram_rdata[CW*c +: CW]} * {{(HW-WW){1'b0}}, d_w};
      vprod[c] = {{(VW-HW){1'b0}}, upper_r[c]} * {{(VW-WW){1'b0}}, d_wy};
      esum[c]  = {{(RW-VW){1'b0}}, vacc_r[c]}
               + ({{(RW-HW){1'b0}}, lower_r[c]} * {{(RW-FRAC_W){1'b0}}, e_fy_r})
               + bis_pkg::ROUND_HALF;
      e_pixel[CW*c +: CW] = esum[c][bis_pkg::RND_SHIFT +: CW];
    end
  end

  always_ff @(posedge clk) begin
    d_phase_r <= phase_r;
    d_fx_r    <= iss_x_r.frac;
    d_fy_r    <= iss_fy_r;
    if (d_read_r) begin
      unique case (d_phase_r)
        bis_pkg::PH_P00: begin
          for (int c = 0; c < NCH; c++) begin
            hacc_r[c] <= hprod[c];
          end
        end
        bis_pkg::PH_P01: begin
          for (int c = 0; c < NCH; c++) begin
            upper_r[c] <= hacc_r[c] + hprod[c];
          end
        end
        bis_pkg::PH_P10: begin
          for (int c = 0; c < NCH; c++) begin
            hacc_r[c] <= hprod[c];
            vacc_r[c] <= vprod[c];
          end
        end
        bis_pkg::PH_P11: begin
          for (int c = 0; c < NCH; c++) begin
            lower_r[c] <= hacc_r[c] + hprod[c];
          end
          e_fy_r <= d_fy_r;
        end
      endcase
    end
    out_pixel_r <= e_bad_r ? '0 : e_pixel;
    out_bad_r   <= e_bad_r;
  end

  assign out_valid        = out_valid_r;
  assign out_result_pixel = out_pixel_r;
  assign out_bad_request  = out_bad_r;

  a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
    (iss_read && (phase_r == bis_pkg::PH_P00)) |=> (phase_r == bis_pkg::PH_P01))
    else $error("read sequence skipped a neighbour");

  a_hold_issue: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (iss_valid_r && $stable(iss_tag_r)))
    else $error("issued command changed while busy");

  a_write_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> !d_read_r)
    else $error("store write overlapped a neighbour read");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_request) |-> (out_result_pixel == '0))
    else $error("out-of-range request returned nonzero pixel");

endmodule
